// File: rtl/mhfp_pkg.sv
// shared types, codes and name tables for the mail header field parser
// no dependencies; imported by mail_header_field_parser

package mhfp_pkg;

	// parse phases
	localparam logic [2:0] PH_LINE  = 3'd0;
	localparam logic [2:0] PH_FIELD = 3'd1;
	localparam logic [2:0] PH_CR    = 3'd2;
	localparam logic [2:0] PH_FOLD  = 3'd3;
	localparam logic [2:0] PH_COLON = 3'd4;
	localparam logic [2:0] PH_COLCR = 3'd5;

	// result kinds
	localparam logic [2:0] K_NAME  = 3'd0;
	localparam logic [2:0] K_BODY  = 3'd1;
	localparam logic [2:0] K_FEND  = 3'd2;
	localparam logic [2:0] K_HEND  = 3'd3;
	localparam logic [2:0] K_ERROR = 3'd4;

	// field classes
	localparam logic [2:0] CLS_TO      = 3'd0;
	localparam logic [2:0] CLS_FROM    = 3'd1;
	localparam logic [2:0] CLS_SUBJECT = 3'd2;
	localparam logic [2:0] CLS_MSGID   = 3'd3;
	localparam logic [2:0] CLS_DATE    = 3'd4;
	localparam logic [2:0] CLS_UNKNOWN = 3'd5;

	localparam int NUM_NAMES = 5;
	localparam int MAX_RES   = 3;

	// characters
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DASH  = 8'h2D;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] value;
		logic [2:0] field_class;
		logic       final_of_run;
	} res_t;

	function automatic logic [3:0] known_len(input logic [2:0] idx);
		logic [3:0] len;
		case (idx)
			CLS_TO:      len = 4'd2;
			CLS_FROM:    len = 4'd4;
			CLS_SUBJECT: len = 4'd7;
			CLS_MSGID:   len = 4'd10;
			CLS_DATE:    len = 4'd4;
			default:     len = 4'd0;
		endcase
		return len;
	endfunction

	// upper-case letter of a known name at a position, 0 past its end
	function automatic logic [7:0] known_char(input logic [2:0] idx, input logic [3:0] pos);
		logic [7:0] c;
		c = 8'h00;
		case (idx)
			CLS_TO: begin
				case (pos)
					4'd0:    c = "T";
					4'd1:    c = "O";
					default: c = 8'h00;
				endcase
			end
			CLS_FROM: begin
				case (pos)
					4'd0:    c = "F";
					4'd1:    c = "R";
					4'd2:    c = "O";
					4'd3:    c = "M";
					default: c = 8'h00;
				endcase
			end
			CLS_SUBJECT: begin
				case (pos)
					4'd0:    c = "S";
					4'd1:    c = "U";
					4'd2:    c = "B";
					4'd3:    c = "J";
					4'd4:    c = "E";
					4'd5:    c = "C";
					4'd6:    c = "T";
					default: c = 8'h00;
				endcase
			end
			CLS_MSGID: begin
				case (pos)
					4'd0:    c = "M";
					4'd1:    c = "E";
					4'd2:    c = "S";
					4'd3:    c = "S";
					4'd4:    c = "A";
					4'd5:    c = "G";
					4'd6:    c = "E";
					4'd7:    c = CH_DASH;
					4'd8:    c = "I";
					4'd9:    c = "D";
					default: c = 8'h00;
				endcase
			end
			CLS_DATE: begin
				case (pos)
					4'd0:    c = "D";
					4'd1:    c = "A";
					4'd2:    c = "T";
					4'd3:    c = "E";
					default: c = 8'h00;
				endcase
			end
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// drop the candidates that the next name byte rules out
	function automatic logic [4:0] track_flags(input logic [3:0] pos, input logic [4:0] flags,
		input logic [7:0] b);
		logic [7:0] up;
		logic [4:0] nf;
		up = (b >= "a" && b <= "z") ? (b - 8'd32) : b;
		nf = flags;
		for (int i = 0; i < NUM_NAMES; i++) begin
			if (pos >= known_len(3'(i)) || known_char(3'(i), pos) != up)
				nf[i] = 1'b0;
		end
		return nf;
	endfunction

	// first surviving candidate whose length equals the name length
	function automatic logic [2:0] classify(input logic [3:0] pos, input logic [4:0] flags);
		logic [2:0] cls;
		cls = CLS_UNKNOWN;
		for (int i = NUM_NAMES - 1; i >= 0; i--) begin
			if (flags[i] && pos == known_len(3'(i)))
				cls = 3'(i);
		end
		return cls;
	endfunction

	function automatic res_t make_res(input logic [2:0] kind, input logic [7:0] value,
		input logic [2:0] cls);
		res_t r;
		r.kind         = kind;
		r.value        = value;
		r.field_class  = cls;
		r.final_of_run = 1'b0;
		return r;
	endfunction

endpackage

// File: rtl/mail_header_field_parser.sv
// mail header field parser: one header byte in, up to three results out
// depends on mhfp_pkg (codes, name tables, result type)
//
// channel | handshake           | payload
// --------+---------------------+--------------------------------------------
// in      | in_valid / in_ready | data_byte[7:0], end_of_flow
// out     | out_valid/out_ready | kind[2:0], value[7:0], field_class[2:0],
//         |                     | final_of_run
//
// a request waits in the input register until the batch can take it, then its
// results (0 to 3) land in a three-slot result batch whose slot 0 drives out
// one request a cycle is taken while each gives at most one result and out_ready
// is high; after a request with more results the next request waits in the input
// register while the single result port drains the batch
// arst_n clears the parse state, the valid bit of the input register and the
// batch count; payload registers are not reset
// a stall on out holds the batch, then the input register, then in_ready

module mail_header_field_parser
	import mhfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       end_of_flow,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] kind,
	output logic [7:0] value,
	output logic [2:0] field_class,
	output logic       final_of_run
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;

	// parse state
	logic [2:0] phase_q;
	logic       in_body_q;
	logic [3:0] npos_q;
	logic [4:0] flags_q;
	logic       halted_q;

	// result batch, slot 0 is the one on the port
	res_t       batch_q [MAX_RES];
	logic [1:0] cnt_q;

	// next-state and result logic
	logic [2:0] ph;
	logic       ib;
	logic [3:0] np;
	logic [4:0] fl;
	logic       hl;
	res_t       r [MAX_RES];
	logic [1:0] n;
	logic       do_fb, do_fend, do_ls, do_fail;
	logic       adv;
	logic       out_take;

	assign out_valid    = (cnt_q != 2'd0);
	assign kind         = batch_q[0].kind;
	assign value        = batch_q[0].value;
	assign field_class  = batch_q[0].field_class;
	assign final_of_run = batch_q[0].final_of_run;
	assign out_take     = out_valid && out_ready;

	// the input register moves on once the batch is empty or its last result leaves
	assign adv      = valid_s1 && (cnt_q == 2'd0 || (cnt_q == 2'd1 && out_ready));
	assign in_ready = !valid_s1 || adv;

	always_comb begin
		ph      = phase_q;
		ib      = in_body_q;
		np      = npos_q;
		fl      = flags_q;
		hl      = halted_q;
		n       = 2'd0;
		do_fb   = 1'b0;
		do_fend = 1'b0;
		do_ls   = 1'b0;
		do_fail = 1'b0;
		for (int i = 0; i < MAX_RES; i++)
			r[i] = make_res(K_NAME, 8'h00, CLS_TO);

		// what this byte does in the current phase
		case (phase_q)
			PH_FIELD: do_fb = 1'b1;
			PH_CR: begin
				if (byte_s1 == CH_LF)
					ph = PH_FOLD;
				else
					do_fb = 1'b1;
			end
			PH_FOLD: begin
				if (byte_s1 == CH_SP || byte_s1 == CH_TAB) begin
					do_fb = 1'b1;
				end else begin
					do_fend = 1'b1;
					do_ls   = 1'b1;
				end
			end
			PH_COLON: begin
				if (byte_s1 == CH_SP)
					ph = PH_FIELD;
				else if (byte_s1 == CH_CR)
					ph = PH_COLCR;
				else
					do_fail = 1'b1;
			end
			PH_COLCR: begin
				if (byte_s1 == CH_LF)
					ph = PH_FOLD;
				else
					do_fail = 1'b1;
			end
			default: do_ls = 1'b1;
		endcase

		if (!halted_q) begin
			// line break followed by a non-blank closes the field
			if (do_fend) begin
				if (n != 2'd3) begin
					r[n] = make_res(K_FEND, 8'h00, classify(np, fl));
					n = n + 2'd1;
				end
				ib = 1'b0;
				np = 4'd0;
				fl = 5'h1F;
				ph = PH_LINE;
			end
			// line opening with a break is the blank line
			if (do_ls) begin
				if (byte_s1 == CH_CR || byte_s1 == CH_LF) begin
					if (n != 2'd3) begin
						r[n] = make_res(K_HEND, 8'h00, CLS_TO);
						n = n + 2'd1;
					end
					hl = 1'b1;
				end else begin
					do_fb = 1'b1;
				end
			end
			if (do_fb) begin
				if (byte_s1 == CH_CR) begin
					ph = PH_CR;
				end else if (byte_s1 == CH_LF) begin
					ph = PH_FOLD;
				end else if (byte_s1 == CH_COLON && !ib) begin
					ib = 1'b1;
					ph = PH_COLON;
				end else begin
					ph = PH_FIELD;
					if (ib) begin
						if (n != 2'd3) begin
							r[n] = make_res(K_BODY, byte_s1, CLS_TO);
							n = n + 2'd1;
						end
					end else begin
						fl = track_flags(np, fl, byte_s1);
						if (np != 4'd15)
							np = np + 4'd1;
						if (n != 2'd3) begin
							r[n] = make_res(K_NAME, byte_s1, CLS_TO);
							n = n + 2'd1;
						end
					end
				end
			end
			if (do_fail) begin
				if (n != 2'd3) begin
					r[n] = make_res(K_ERROR, 8'h00, CLS_TO);
					n = n + 2'd1;
				end
				hl = 1'b1;
			end
			// last byte: a pending break closes field and header, else the line is cut
			if (eof_s1 && !hl) begin
				if (ph == PH_CR || ph == PH_FOLD) begin
					if (n != 2'd3) begin
						r[n] = make_res(K_FEND, 8'h00, classify(np, fl));
						n = n + 2'd1;
					end
					ib = 1'b0;
					np = 4'd0;
					fl = 5'h1F;
					ph = PH_LINE;
					if (n != 2'd3) begin
						r[n] = make_res(K_HEND, 8'h00, CLS_TO);
						n = n + 2'd1;
					end
				end else begin
					if (n != 2'd3) begin
						r[n] = make_res(K_ERROR, 8'h00, CLS_TO);
						n = n + 2'd1;
					end
				end
				hl = 1'b1;
			end
			if (n != 2'd0)
				r[n - 2'd1].final_of_run = 1'b1;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			eof_s1  <= end_of_flow;
		end
	end

	// parse state advances with each request leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_LINE;
			in_body_q <= 1'b0;
			npos_q    <= 4'd0;
			flags_q   <= 5'h1F;
			halted_q  <= 1'b0;
		end else if (adv) begin
			phase_q   <= ph;
			in_body_q <= ib;
			npos_q    <= np;
			flags_q   <= fl;
			halted_q  <= hl;
		end
	end

	// result batch count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (adv) begin
			cnt_q <= n;
		end else if (out_take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// result batch payload: load on advance, shift toward slot 0 on each take
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < MAX_RES; i++)
				batch_q[i] <= r[i];
		end else if (out_take) begin
			batch_q[0] <= batch_q[1];
			batch_q[1] <= batch_q[2];
		end
	end

	// once halted, the parser stays halted until reset
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("parser left the halted state");

	// header end is always the last result of its request
	a_hend_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == K_HEND) |-> final_of_run)
		else $error("header end not marked final");

	// the final result of a request sits only in the last occupied slot
	a_final_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && final_of_run) |-> (cnt_q == 2'd1))
		else $error("final result with more results queued behind it");

	// nothing is produced after a halt
	a_quiet_halt: assert property (@(posedge clk) disable iff (!arst_n)
		(halted_q && cnt_q == 2'd0) |=> (cnt_q == 2'd0))
		else $error("result produced while halted");

endmodule
